>>> hdl/bol_pkg.sv
`default_nettype none

package bol_pkg;

    // Request codes carried in the input tuser.
    localparam logic [2:0] OP_INSERT = 3'd0;
    localparam logic [2:0] OP_DELETE = 3'd1;
    localparam logic [2:0] OP_SEARCH = 3'd2;
    localparam logic [2:0] OP_ROTATE = 3'd3;
    localparam logic [2:0] OP_READ   = 3'd4;

    // Status codes returned with every result.
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;
    localparam logic [1:0] ST_BADPOS = 2'd3;

    // Width of the rotate amount and of its bit index for the serial remainder.
    localparam int unsigned AMT_W     = 8;
    localparam int unsigned AMT_BIT_W = 3;

    // What every cell of the chain does, as set by the broadcast command.
    typedef enum logic [1:0] {
        ACT_HOLD   = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_DELETE = 2'd2,
        ACT_ROTL   = 2'd3
    } t_action;

    // Broadcast command to the chain; cells compare their own index against it.
    typedef struct packed {
        t_action    action;
        logic [7:0] first;
        logic [7:0] limit;
    } t_chain_cmd;

    // One result transaction.
    typedef struct packed {
        logic [3:0]         entry_count;
        logic signed [31:0] read_value;
        logic               found;
        logic [1:0]         status;
    } t_result;

endpackage

`default_nettype wire

>>> hdl/bol_cell.sv
`default_nettype none

// One slot of the list. It keeps its word or takes the word of a neighbour,
// the new value or the head of the list, as the broadcast command says.
module bol_cell (
    input  wire                  i_clk,
    input  wire [7:0]            i_index,
    input  wire bol_pkg::t_chain_cmd i_cmd,
    input  wire [31:0]           i_value,
    input  wire [31:0]           i_left,
    input  wire [31:0]           i_right,
    input  wire [31:0]           i_head,
    output logic [31:0]          o_q
);

    logic [31:0] r_word;
    logic [31:0] n_word;
    logic [8:0]  idx_plus1;

    assign idx_plus1 = {1'b0, i_index} + 9'd1;

    // Choose the next word for this slot.
    always_comb begin
        n_word = r_word;
        case (i_cmd.action)
            bol_pkg::ACT_INSERT: begin
                if (i_index == i_cmd.first) begin
                    n_word = i_value;
                end else if (i_index > i_cmd.first && i_index < i_cmd.limit) begin
                    n_word = i_left;
                end
            end
            bol_pkg::ACT_DELETE: begin
                if (i_index >= i_cmd.first && idx_plus1 < {1'b0, i_cmd.limit}) begin
                    n_word = i_right;
                end
            end
            bol_pkg::ACT_ROTL: begin
                if (idx_plus1 < {1'b0, i_cmd.limit}) begin
                    n_word = i_right;
                end else if (idx_plus1 == {1'b0, i_cmd.limit}) begin
                    n_word = i_head;
                end
            end
            default: begin
                n_word = r_word;
            end
        endcase
    end

    // Payload register, no reset needed.
    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_q = r_word;

endmodule

`default_nettype wire

>>> hdl/bol_ctrl.sv
`default_nettype none

// Sequencer for the list: checks requests, keeps the count, steers the chain
// of cells and holds the result register.
module bol_ctrl #(
    parameter int unsigned CAPACITY = 8
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  wire [2:0]            i_op,
    input  wire [31:0]           i_item_value,
    input  wire [7:0]            i_position,
    input  wire [7:0]            i_rotate_amount,
    input  wire [31:0]           i_head,
    output bol_pkg::t_chain_cmd  o_cmd,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output bol_pkg::t_result     o_result
);

    localparam int unsigned CW = $clog2(CAPACITY + 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIV  = 5'b00010,
        S_ROT  = 5'b00100,
        S_SCAN = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state                         r_state;
    logic [CW-1:0]                  r_count;
    logic [2:0]                     r_op;
    logic [31:0]                    r_val;
    logic [7:0]                     r_pos;
    logic [bol_pkg::AMT_W-1:0]      r_k;
    logic [bol_pkg::AMT_BIT_W-1:0]  r_bit;
    logic [CW-1:0]                  r_rem;
    logic [CW-1:0]                  r_step;
    logic [1:0]                     r_status;
    logic                           r_found;
    logic [31:0]                    r_rd;
    logic                           r_out_valid;
    bol_pkg::t_result               r_result;

    logic          accept;
    logic [8:0]    pos9;
    logic [8:0]    cnt9;
    logic          full;
    logic          empty;
    logic          ins_pos_ok;
    logic          live_pos_ok;
    logic [CW:0]   trial;
    logic          trial_ge;
    logic [CW-1:0] rem_next;
    logic [CW-1:0] cnt_m1;
    logic [1:0]    chk_status;
    t_state        acc_state;

    assign accept      = i_in_valid && (r_state == S_IDLE);
    assign o_in_ready  = (r_state == S_IDLE);
    assign pos9        = {1'b0, i_position};
    assign cnt9        = 9'(r_count);
    assign full        = (r_count >= CW'(CAPACITY));
    assign empty       = (r_count == '0);
    assign ins_pos_ok  = (i_position != 8'd0) && (pos9 <= cnt9 + 9'd1);
    assign live_pos_ok = (i_position != 8'd0) && (pos9 <= cnt9);
    assign cnt_m1      = r_count - CW'(1);

    // One step of the restoring remainder of the rotate amount by the count.
    assign trial    = {r_rem, r_k[r_bit]};
    assign trial_ge = (trial >= {1'b0, r_count});
    assign rem_next = trial_ge ? CW'(trial - {1'b0, r_count}) : CW'(trial);

    // Status of an offered request and the state it leads to.
    always_comb begin
        chk_status = bol_pkg::ST_OK;
        acc_state  = S_DONE;
        case (i_op)
            bol_pkg::OP_INSERT: begin
                if (full) begin
                    chk_status = bol_pkg::ST_FULL;
                end else if (!ins_pos_ok) begin
                    chk_status = bol_pkg::ST_BADPOS;
                end
            end
            bol_pkg::OP_DELETE: begin
                if (empty) begin
                    chk_status = bol_pkg::ST_EMPTY;
                end else if (!live_pos_ok) begin
                    chk_status = bol_pkg::ST_BADPOS;
                end
            end
            bol_pkg::OP_READ: begin
                if (empty) begin
                    chk_status = bol_pkg::ST_EMPTY;
                end else if (!live_pos_ok) begin
                    chk_status = bol_pkg::ST_BADPOS;
                end else begin
                    acc_state = S_SCAN;
                end
            end
            bol_pkg::OP_ROTATE: begin
                if (empty) begin
                    chk_status = bol_pkg::ST_EMPTY;
                end else begin
                    acc_state = S_DIV;
                end
            end
            bol_pkg::OP_SEARCH: begin
                if (!empty) begin
                    acc_state = S_SCAN;
                end
            end
            default: begin
                chk_status = bol_pkg::ST_OK;
                acc_state  = S_DONE;
            end
        endcase
    end

    // Command broadcast to the chain of cells.
    always_comb begin
        o_cmd.action = bol_pkg::ACT_HOLD;
        o_cmd.first  = 8'd0;
        o_cmd.limit  = 8'd0;
        if (accept && i_op == bol_pkg::OP_INSERT && !full && ins_pos_ok) begin
            o_cmd.action = bol_pkg::ACT_INSERT;
            o_cmd.first  = i_position - 8'd1;
            o_cmd.limit  = 8'(cnt9 + 9'd1);
        end else if (accept && i_op == bol_pkg::OP_DELETE && !empty && live_pos_ok) begin
            o_cmd.action = bol_pkg::ACT_DELETE;
            o_cmd.first  = i_position - 8'd1;
            o_cmd.limit  = 8'(cnt9);
        end else if (r_state == S_SCAN || r_state == S_ROT) begin
            o_cmd.action = bol_pkg::ACT_ROTL;
            o_cmd.limit  = 8'(cnt9);
        end
    end

    // Working registers of the request in progress.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    r_op     <= i_op;
                    r_val    <= i_item_value;
                    r_pos    <= i_position - 8'd1;
                    r_k      <= i_rotate_amount;
                    r_bit    <= bol_pkg::AMT_BIT_W'(bol_pkg::AMT_W - 1);
                    r_rem    <= '0;
                    r_step   <= '0;
                    r_found  <= 1'b0;
                    r_rd     <= 32'd0;
                    r_status <= chk_status;
                end
            end
            S_DIV: begin
                r_rem <= rem_next;
                r_bit <= r_bit - bol_pkg::AMT_BIT_W'(1);
                r_step <= r_count - rem_next;
            end
            S_ROT: begin
                r_step <= r_step - CW'(1);
            end
            S_SCAN: begin
                // The head cell holds the entry at position r_step + 1.
                if (r_op == bol_pkg::OP_SEARCH && i_head == r_val) begin
                    r_found <= 1'b1;
                end
                if (r_op == bol_pkg::OP_READ && 8'(r_step) == r_pos) begin
                    r_rd <= i_head;
                end
                r_step <= r_step + CW'(1);
            end
            default: begin
                r_step <= r_step;
            end
        endcase
    end

    // Sequencer, count and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= acc_state;
                        case (i_op)
                            bol_pkg::OP_INSERT: begin
                                if (!full && ins_pos_ok) begin
                                    r_count <= r_count + CW'(1);
                                end
                            end
                            bol_pkg::OP_DELETE: begin
                                if (!empty && live_pos_ok) begin
                                    r_count <= r_count - CW'(1);
                                end
                            end
                            default: begin
                                r_count <= r_count;
                            end
                        endcase
                    end
                end
                S_DIV: begin
                    if (r_bit == '0) begin
                        r_state <= (rem_next == '0) ? S_DONE : S_ROT;
                    end
                end
                S_ROT: begin
                    if (r_step == CW'(1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_SCAN: begin
                    if (r_step == cnt_m1) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Result payload, loaded as the transaction leaves the sequencer.
    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && (!r_out_valid || i_out_ready)) begin
            r_result.status      <= r_status;
            r_result.found       <= r_found;
            r_result.read_value  <= r_rd;
            r_result.entry_count <= 4'(r_count);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

endmodule

`default_nettype wire

>>> hdl/bounded_ordered_list_top.sv
// Insert, delete, rejected requests and unused codes go straight to the done state.
// Search and read: one chain rotation per entry; a search of an empty list has none.
// Rotate: serial remainder by the count, then up to count - 1 single-step rotations.
// One request is in work at a time; the next is taken once the sequencer is idle.
// Synchronous active-low reset clears the count, the sequencer and the output valid;
// the entry cells are not reset.
`default_nettype none

module bounded_ordered_list_top #(
    parameter int unsigned CAPACITY = 8
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire [47:0]  s_axis_tdata,   // item_value[31:0], position[39:32], rotate_amount[47:40]
    input  wire [2:0]   s_axis_tuser,   // op[2:0]
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [39:0] m_axis_tdata    // status[1:0], found[2], read_value[34:3],
                                        // entry_count[38:35], zero fill[39]
);

    bol_pkg::t_chain_cmd cmd;
    bol_pkg::t_result    result;
    logic [31:0]         cell_q [CAPACITY];

    // Sequencer and result register.
    bol_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (s_axis_tvalid),
        .o_in_ready      (s_axis_tready),
        .i_op            (s_axis_tuser),
        .i_item_value    (s_axis_tdata[31:0]),
        .i_position      (s_axis_tdata[39:32]),
        .i_rotate_amount (s_axis_tdata[47:40]),
        .i_head          (cell_q[0]),
        .o_cmd           (cmd),
        .o_out_valid     (m_axis_tvalid),
        .i_out_ready     (m_axis_tready),
        .o_result        (result)
    );

    // Chain of entry cells wired to the head and neighbours; end cells wrap to themselves.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [31:0] left_q;
        logic [31:0] right_q;

        if (g == 0) begin : g_first
            assign left_q = cell_q[0];
        end else begin : g_mid
            assign left_q = cell_q[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign right_q = cell_q[g];
        end else begin : g_inner
            assign right_q = cell_q[g+1];
        end

        bol_cell u_cell (
            .i_clk   (i_clk),
            .i_index (8'(g)),
            .i_cmd   (cmd),
            .i_value (s_axis_tdata[31:0]),
            .i_left  (left_q),
            .i_right (right_q),
            .i_head  (cell_q[0]),
            .o_q     (cell_q[g])
        );
    end

    // Pack the result, status in the lowest bits.
    assign m_axis_tdata = {1'b0, result.entry_count, result.read_value,
                           result.found, result.status};

endmodule

`default_nettype wire
